[rtl/qtl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtl_pkg
// Shared types and constants of the query token lexer.
// ----------------------------------------------------------------------------
package qtl_pkg;

    localparam int MAX_COMMAND_BYTES = 4096;

    localparam int KIND_W = 4;
    localparam int POS_W  = 12;
    localparam int LEN_W  = 13;

    // saturation bounds of offsets and lengths
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_COMMAND_BYTES - 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_COMMAND_BYTES);

    // token queue between lexer and output side
    localparam int QDEPTH = 4;
    localparam int QIDX_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        K_END    = 4'd0,
        K_LP     = 4'd1,
        K_RP     = 4'd2,
        K_COMMA  = 4'd3,
        K_PROX   = 4'd4,
        K_REL    = 4'd5,
        K_EQ     = 4'd6,
        K_MINUS  = 4'd7,
        K_TERM   = 4'd8,
        K_AND    = 4'd9,
        K_OR     = 4'd10,
        K_NOT    = 4'd11,
        K_SET    = 4'd12
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [POS_W-1:0]   start;
        logic [LEN_W-1:0]   length;
        logic               last;
    } t_token;

    // up to two tokens per accepted byte: a closed held token, then a new one
    typedef struct packed {
        logic   v0;
        t_token tok0;
        logic   v1;
        t_token tok1;
    } t_push;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              room;
    } t_qstat;

endpackage

[rtl/qtl_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtl_ifs
// Valid/ready channels: command bytes in, tokens out.
// ----------------------------------------------------------------------------
interface qtl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface

interface qtl_tok_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [11:0] token_start;
    logic [12:0] token_length;
    logic        last_of_command;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output last_of_command, input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input last_of_command, output ready);
endinterface

[rtl/qtl_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtl_front
// Byte classifier and token state machine; pushes finished tokens.
// ----------------------------------------------------------------------------
module qtl_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    qtl_byte_if.sink         i_byte,
    input  qtl_pkg::t_qstat  i_qstat,
    output qtl_pkg::t_push   o_push
);
    import qtl_pkg::*;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_LP    = 8'h28;
    localparam logic [7:0] CH_RP    = 8'h29;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;

    // keywords, first byte in the low lane
    localparam logic [23:0] KW_AND = 24'h646E61;
    localparam logic [23:0] KW_NOT = 24'h746F6E;
    localparam logic [23:0] KW_SET = 24'h746573;
    localparam logic [23:0] KW_OR  = 24'h00726F;

    typedef enum logic [4:0] {
        M_IDLE  = 5'b00001,
        M_PROX  = 5'b00010,
        M_REL   = 5'b00100,
        M_WORD  = 5'b01000,
        M_QUOTE = 5'b10000
    } t_mode;

    t_mode            r_mode, n_mode;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_pstart, n_pstart;
    logic [LEN_W-1:0] r_plen, n_plen;
    logic [23:0]      r_fwb, n_fwb;
    logic [7:0]       r_pop, n_pop;

    logic             accept;
    logic [7:0]       b;
    logic             is_space, is_rel, is_prox, ends_word;
    logic [POS_W-1:0] pos_inc;
    logic [LEN_W-1:0] len_inc;
    logic             do_start;
    t_kind            wkind;
    t_push            push;

    assign i_byte.ready = i_qstat.room;
    assign accept       = i_byte.valid & i_qstat.room;
    assign b            = i_byte.char_byte;

    assign is_space  = (b == CH_SP) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    assign is_rel    = (b == CH_LT) || (b == CH_GT) || (b == CH_EQ);
    assign is_prox   = (b == CH_PCT) || (b == CH_BANG);
    assign ends_word = (b == CH_NUL) || is_space || (b == CH_LP) || (b == CH_RP) ||
                       (b == CH_COMMA) || is_prox || is_rel || (b == CH_MINUS);

    assign pos_inc = (({1'b0, r_pos} + 13'd1) > {1'b0, POS_MAX}) ? POS_MAX
                                                                  : r_pos + 1'b1;
    assign len_inc = (({1'b0, r_plen} + 14'd1) > {1'b0, LEN_MAX}) ? LEN_MAX
                                                                   : r_plen + 1'b1;

    always_comb begin
        wkind = K_TERM;
        if (r_plen == LEN_W'(3)) begin
            if (r_fwb == KW_AND) wkind = K_AND;
            else if (r_fwb == KW_NOT) wkind = K_NOT;
            else if (r_fwb == KW_SET) wkind = K_SET;
        end else if (r_plen == LEN_W'(2)) begin
            if (r_fwb == KW_OR) wkind = K_OR;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_pos    = pos_inc;
        n_pstart = r_pstart;
        n_plen   = r_plen;
        n_fwb    = r_fwb;
        n_pop    = r_pop;
        do_start = 1'b0;
        push     = '0;
        push.tok0.start = r_pstart;
        push.tok0.kind  = K_TERM;
        push.tok1.start = r_pos;
        push.tok1.length = LEN_W'(1);
        push.tok1.kind  = K_END;

        // held token: extend it or close it into slot 0
        unique case (r_mode)
            M_PROX: begin
                if (is_prox) begin
                    n_plen = len_inc;
                end else begin
                    push.v0          = 1'b1;
                    push.tok0.kind   = K_PROX;
                    push.tok0.length = r_plen;
                    do_start         = 1'b1;
                end
            end
            M_REL: begin
                push.v0 = 1'b1;
                if (is_rel) begin
                    push.tok0.kind   = K_REL;
                    push.tok0.length = LEN_W'(2);
                    n_mode           = M_IDLE;
                end else begin
                    push.tok0.kind   = (r_pop == CH_EQ) ? K_EQ : K_REL;
                    push.tok0.length = LEN_W'(1);
                    do_start         = 1'b1;
                end
            end
            M_WORD: begin
                if (ends_word) begin
                    push.v0          = 1'b1;
                    push.tok0.kind   = wkind;
                    push.tok0.length = r_plen;
                    do_start         = 1'b1;
                end else begin
                    case (r_plen)
                        LEN_W'(1): n_fwb[15:8]  = b;
                        LEN_W'(2): n_fwb[23:16] = b;
                        default:   n_fwb        = r_fwb;
                    endcase
                    n_plen = len_inc;
                end
            end
            M_QUOTE: begin
                if (b == CH_NUL) begin
                    push.v0          = 1'b1;
                    push.tok0.length = r_plen;
                    do_start         = 1'b1;
                end else if (b == CH_QUOTE) begin
                    push.v0          = 1'b1;
                    push.tok0.length = r_plen;
                    n_mode           = M_IDLE;
                end else begin
                    n_plen = len_inc;
                end
            end
            default: begin
                do_start = 1'b1;
            end
        endcase

        // byte starts a new token; one-byte tokens go to slot 1
        if (do_start) begin
            n_mode = M_IDLE;
            if (!is_space) begin
                unique case (b)
                    CH_NUL: begin
                        push.v1        = 1'b1;
                        push.tok1.kind = K_END;
                        push.tok1.last = 1'b1;
                        n_pos          = '0;
                    end
                    CH_LP: begin
                        push.v1        = 1'b1;
                        push.tok1.kind = K_LP;
                    end
                    CH_RP: begin
                        push.v1        = 1'b1;
                        push.tok1.kind = K_RP;
                    end
                    CH_COMMA: begin
                        push.v1        = 1'b1;
                        push.tok1.kind = K_COMMA;
                    end
                    CH_MINUS: begin
                        push.v1        = 1'b1;
                        push.tok1.kind = K_MINUS;
                    end
                    CH_PCT, CH_BANG: begin
                        n_mode   = M_PROX;
                        n_pstart = r_pos;
                        n_plen   = LEN_W'(1);
                    end
                    CH_LT, CH_GT, CH_EQ: begin
                        n_mode   = M_REL;
                        n_pstart = r_pos;
                        n_plen   = LEN_W'(1);
                        n_pop    = b;
                    end
                    CH_QUOTE: begin
                        n_mode   = M_QUOTE;
                        n_pstart = pos_inc;
                        n_plen   = '0;
                    end
                    default: begin
                        n_mode   = M_WORD;
                        n_pstart = r_pos;
                        n_plen   = LEN_W'(1);
                        n_fwb    = {16'h0000, b};
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_push    = push;
        o_push.v0 = push.v0 & accept;
        o_push.v1 = push.v1 & accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_pstart <= '0;
            r_plen   <= '0;
            r_fwb    <= '0;
            r_pop    <= '0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_pstart <= n_pstart;
            r_plen   <= n_plen;
            r_fwb    <= n_fwb;
            r_pop    <= n_pop;
        end
    end

endmodule

[rtl/qtl_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtl_queue
// Token queue: takes up to two tokens a cycle, delivers one to the port.
// ----------------------------------------------------------------------------
module qtl_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  qtl_pkg::t_push   i_push,
    output qtl_pkg::t_qstat  o_qstat,
    qtl_tok_if.source        o_tok
);
    import qtl_pkg::*;

    t_token             r_mem [QDEPTH];
    logic [QIDX_W-1:0]  r_wr, n_wr;
    logic [QIDX_W-1:0]  r_rd, n_rd;
    logic [QCNT_W-1:0]  r_cnt, n_cnt;
    logic [QIDX_W-1:0]  wr_b;
    logic               pop;
    logic [1:0]         npush;
    t_token             head;

    assign pop   = o_tok.valid & o_tok.ready;
    assign npush = {1'b0, i_push.v0} + {1'b0, i_push.v1};
    assign wr_b  = r_wr + QIDX_W'(i_push.v0);

    assign n_wr  = r_wr + QIDX_W'(npush);
    assign n_rd  = r_rd + QIDX_W'(pop);
    assign n_cnt = r_cnt + QCNT_W'(npush) - QCNT_W'(pop);

    assign head                  = r_mem[r_rd];
    assign o_tok.valid           = (r_cnt != '0);
    assign o_tok.token_kind      = head.kind;
    assign o_tok.token_start     = head.start;
    assign o_tok.token_length    = head.length;
    assign o_tok.last_of_command = head.last;

    // a byte may go in only while two entries are free
    assign o_qstat.count = r_cnt;
    assign o_qstat.room  = (r_cnt <= QCNT_W'(QDEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.v0) r_mem[r_wr] <= i_push.tok0;
        if (i_push.v1) r_mem[wr_b] <= i_push.tok1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

[rtl/query_token_lexer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// query_token_lexer
// Splits a byte stream of query commands into kind/offset/length tokens.
// ----------------------------------------------------------------------------
// Tokens are registered in the token queue before they reach the output.
// Throughput: one byte per cycle; the four-entry token queue takes a byte only
//   while two entries are free, so input stalls only when the output stalls.
// A byte makes at most two tokens; two in a row never follow each other.
// Reset (i_rst_n low, synchronous): lexer idle, offset zero, queue empty.
// ----------------------------------------------------------------------------
module query_token_lexer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qtl_byte_if.sink   i_byte,
    qtl_tok_if.source  o_tok
);
    import qtl_pkg::*;

    t_push  push;
    t_qstat qstat;

    // front: classify each byte, hold multi-byte tokens, push closed tokens
    qtl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_qstat (qstat),
        .o_push  (push)
    );

    // back: queue tokens and hand them to the output channel one at a time
    qtl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_qstat (qstat),
        .o_tok   (o_tok)
    );

    // queue occupancy never passes its depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.count <= QCNT_W'(QDEPTH))
        else $error("token queue overflow");

    // the lexer takes a byte only with room for two tokens
    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_byte.valid && i_byte.ready) |-> (qstat.count <= QCNT_W'(QDEPTH - 2)))
        else $error("byte accepted without queue room");

    // output offers a token exactly when the queue holds one
    a_out_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok.valid == (qstat.count != '0))
        else $error("output valid disagrees with queue count");

    // the end-of-command marker only rides on an end token
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok.valid && o_tok.last_of_command) |-> (o_tok.token_kind == K_END))
        else $error("last_of_command on a non-end token");

endmodule
